/* rtl/scan_polar_to_cartesian_core_assert.svh */
// Assertion macros shared by the RTL of the polar-to-cartesian core.
// Both macros sample on the rising edge of aclk and are disabled while
// aresetn is low, so the module that uses them must have those two ports.
`ifndef SCAN_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spc_pkg.sv */
package spc_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_RANGE_BITS      = 16;
    localparam int DEF_ANGLE_BITS      = 16;
    localparam int DEF_ROTATION_STAGES = 16;

    // Fixed field widths.
    localparam int IN_RANGE_BITS  = 16;
    localparam int INDEX_BITS     = 16;
    localparam int REG_BITS       = 16;
    localparam int OUT_BITS       = 17;
    localparam int CFG_INDEX_BITS = 8;

    // Rotator angle word: units of 2^-32 turn.
    localparam int Z_BITS        = 32;
    localparam int ATAN_ENTRIES  = 24;
    localparam int FRAC_BITS     = 16;
    localparam int OUT_LIMIT     = 65535;

    // CORDIC gain 0.6072529350088813 in Q0.32.
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [Z_BITS-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_START = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_STEP  = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_LOWER = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_UPPER = 8'd3;

    // Quadrant the beam angle was folded from.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Side information that travels with a sample through the rotator.
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        quad_t                 quad;
    } side_t;

endpackage

/* rtl/spc_rot_stage.sv */
// One registered CORDIC micro-rotation with its own valid/ready slot.
module spc_rot_stage #(
    parameter int XW    = 34,
    parameter int STAGE = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [XW-1:0]               in_x,
    input  logic signed [XW-1:0]               in_y,
    input  logic signed [spc_pkg::Z_BITS-1:0]  in_z,
    input  spc_pkg::side_t                     in_side,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [XW-1:0]               out_x,
    output logic signed [XW-1:0]               out_y,
    output logic signed [spc_pkg::Z_BITS-1:0]  out_z,
    output spc_pkg::side_t                     out_side
);

    localparam logic signed [spc_pkg::Z_BITS-1:0] ATAN_STEP =
        signed'(spc_pkg::ATAN_TURN32[STAGE]);

    logic                              valid_reg;
    logic signed [XW-1:0]              x_reg, x_next;
    logic signed [XW-1:0]              y_reg, y_next;
    logic signed [spc_pkg::Z_BITS-1:0] z_reg, z_next;
    spc_pkg::side_t                    side_reg;
    logic signed [XW-1:0]              dx, dy;

    assign in_ready = !valid_reg || out_ready;

    // Arithmetic shifts round toward minus infinity.
    always_comb begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (!in_z[spc_pkg::Z_BITS-1]) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN_STEP;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/scan_polar_to_cartesian_core.sv */
// Channel   | Ports                                                      | Direction
// ----------+------------------------------------------------------------+----------
// sample    | s_valid s_ready s_beam_index s_range_mm s_sample_invalid   | in
// point     | m_valid m_ready m_x_mm m_y_mm m_point_index                | out
// config    | cfg_valid cfg_ready cfg_index cfg_data                     | in
//
// One sample transaction per cycle while m_ready allows; every stage is a register slot
// of its own. Slots in order: window check and step multiply, angle fold and gain
// multiply, one slot per rotation, then rounding, quadrant swap and saturation.
// Reset is synchronous on aresetn low; it empties every slot and loads register defaults.
// A stalled point output holds only the full slots: s_ready stays high while any
// bubble is left in the pipeline, and nothing is dropped or repeated.
`include "scan_polar_to_cartesian_core_assert.svh"

module scan_polar_to_cartesian_core #(
    parameter int RANGE_BITS      = spc_pkg::DEF_RANGE_BITS,
    parameter int ANGLE_BITS      = spc_pkg::DEF_ANGLE_BITS,
    parameter int ROTATION_STAGES = spc_pkg::DEF_ROTATION_STAGES
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [spc_pkg::INDEX_BITS-1:0]       s_beam_index,
    input  logic [spc_pkg::IN_RANGE_BITS-1:0]    s_range_mm,
    input  logic                                 s_sample_invalid,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [spc_pkg::OUT_BITS-1:0]  m_x_mm,
    output logic signed [spc_pkg::OUT_BITS-1:0]  m_y_mm,
    output logic [spc_pkg::INDEX_BITS-1:0]       m_point_index,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [spc_pkg::REG_BITS-1:0]         cfg_data
);

    // Only the low RANGE_BITS bits of the range field take part, and the field
    // is never wider than the input port.
    localparam int RW = (RANGE_BITS < spc_pkg::IN_RANGE_BITS) ?
                        RANGE_BITS : spc_pkg::IN_RANGE_BITS;
    // Rotator x/y: range with 16 fraction bits, plus growth and sign.
    localparam int XW = RW + spc_pkg::FRAC_BITS + 2;
    // Width for the rounded, possibly negated result before saturation.
    localparam int SW = (RW + 3 > spc_pkg::OUT_BITS + 1) ? RW + 3 : spc_pkg::OUT_BITS + 1;
    localparam int A  = ANGLE_BITS;
    localparam int NSTAGE = (ROTATION_STAGES < spc_pkg::ATAN_ENTRIES) ?
                            ROTATION_STAGES : spc_pkg::ATAN_ENTRIES;
    localparam int ZW = spc_pkg::Z_BITS;

    localparam logic [A-1:0]           HALF_QUAD  = A'(1 << (A - 3));
    localparam logic [ZW-1:0]          Z_BIAS     = ZW'(1 << 29);
    localparam logic signed [XW-1:0]   ROUND_HALF = XW'(1 << (spc_pkg::FRAC_BITS - 1));
    localparam logic signed [SW-1:0]   LIMIT      = SW'(spc_pkg::OUT_LIMIT);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the pipeline is
    // idle; the block does not enforce this. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [spc_pkg::REG_BITS-1:0] angle_start_reg;
    logic [spc_pkg::REG_BITS-1:0] angle_step_reg;
    logic [spc_pkg::REG_BITS-1:0] range_lower_reg;
    logic [spc_pkg::REG_BITS-1:0] range_upper_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            range_lower_reg <= '0;
            range_upper_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                spc_pkg::CFG_ANGLE_START: angle_start_reg <= cfg_data;
                spc_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                spc_pkg::CFG_RANGE_LOWER: range_lower_reg <= cfg_data;
                spc_pkg::CFG_RANGE_UPPER: range_upper_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: range window check and step * index product. A sample that
    // is invalid or outside the window is taken but leaves an empty slot.
    // ------------------------------------------------------------------
    logic                               s1_valid_reg, s1_valid_next;
    logic [spc_pkg::INDEX_BITS-1:0]     s1_index_reg;
    logic [RW-1:0]                      s1_range_reg;
    logic [A-1:0]                       s1_prod_reg, s1_prod_next;
    logic [spc_pkg::REG_BITS-1:0]       range_val;
    logic [2*spc_pkg::REG_BITS-1:0]     step_prod;
    logic                               in_window;
    logic                               s2_ready;

    assign s_ready = !s1_valid_reg || s2_ready;

    always_comb begin
        range_val     = spc_pkg::REG_BITS'(s_range_mm[RW-1:0]);
        step_prod     = angle_step_reg * s_beam_index;
        s1_prod_next  = step_prod[A-1:0];
        in_window     = !s_sample_invalid &&
                        (range_val >= range_lower_reg) &&
                        (range_val <= range_upper_reg);
        s1_valid_next = s_valid && in_window;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_index_reg <= s_beam_index;
            s1_range_reg <= s_range_mm[RW-1:0];
            s1_prod_reg  <= s1_prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: beam angle, fold to the nearest quadrant (residual within an
    // eighth of a turn), and the gain-scaled start vector.
    // ------------------------------------------------------------------
    logic                       s2_valid_reg;
    logic signed [XW-1:0]       s2_x_reg, s2_x_next;
    logic signed [ZW-1:0]       s2_z_reg, s2_z_next;
    spc_pkg::side_t             s2_side_reg, s2_side_next;
    logic [31:0]                start_w;
    logic [A-1:0]               angle, folded;
    logic [ZW-1:0]              z_raw;
    logic [RW+31:0]             gain_prod;
    logic                       rot_ready [NSTAGE+1];

    assign s2_ready = !s2_valid_reg || rot_ready[0];

    always_comb begin
        start_w            = {16'h0000, angle_start_reg};
        angle              = start_w[A-1:0] + s1_prod_reg;
        folded             = angle + HALF_QUAD;
        z_raw              = ZW'(folded[A-3:0]) << (ZW - A);
        s2_z_next          = signed'(z_raw - Z_BIAS);
        gain_prod          = s1_range_reg * spc_pkg::GAIN_Q32;
        s2_x_next          = signed'(XW'(gain_prod[RW+31:spc_pkg::FRAC_BITS]));
        s2_side_next.index = s1_index_reg;
        s2_side_next.quad  = spc_pkg::quad_t'(folded[A-1:A-2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_x_reg    <= s2_x_next;
            s2_z_reg    <= s2_z_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Rotation stages: one micro-rotation per register slot.
    // ------------------------------------------------------------------
    logic                   rot_valid [NSTAGE+1];
    logic signed [XW-1:0]   rot_x     [NSTAGE+1];
    logic signed [XW-1:0]   rot_y     [NSTAGE+1];
    logic signed [ZW-1:0]   rot_z     [NSTAGE+1];
    spc_pkg::side_t         rot_side  [NSTAGE+1];
    logic                   out_ready_int;

    assign rot_valid[0]      = s2_valid_reg;
    assign rot_x[0]          = s2_x_reg;
    assign rot_y[0]          = '0;
    assign rot_z[0]          = s2_z_reg;
    assign rot_side[0]       = s2_side_reg;
    assign rot_ready[NSTAGE] = out_ready_int;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_rot
        spc_rot_stage #(
            .XW    (XW),
            .STAGE (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (rot_valid[g]),
            .in_ready  (rot_ready[g]),
            .in_x      (rot_x[g]),
            .in_y      (rot_y[g]),
            .in_z      (rot_z[g]),
            .in_side   (rot_side[g]),
            .out_valid (rot_valid[g+1]),
            .out_ready (rot_ready[g+1]),
            .out_x     (rot_x[g+1]),
            .out_y     (rot_y[g+1]),
            .out_z     (rot_z[g+1]),
            .out_side  (rot_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: round half up, undo the quadrant fold, saturate.
    // The final residual angle is not needed.
    // ------------------------------------------------------------------
    function automatic logic [spc_pkg::OUT_BITS-1:0] sat_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] s;
        begin
            if (v > LIMIT) begin
                s = LIMIT;
            end else if (v < -LIMIT) begin
                s = -LIMIT;
            end else begin
                s = v;
            end
            return s[spc_pkg::OUT_BITS-1:0];
        end
    endfunction

    logic                                 m_valid_reg;
    logic signed [spc_pkg::OUT_BITS-1:0]  m_x_mm_reg, m_x_mm_next;
    logic signed [spc_pkg::OUT_BITS-1:0]  m_y_mm_reg, m_y_mm_next;
    logic [spc_pkg::INDEX_BITS-1:0]       m_point_index_reg;
    logic signed [XW-1:0]                 x_sum, y_sum;
    logic signed [SW-1:0]                 xr, yr, ox, oy;

    assign out_ready_int = !m_valid_reg || m_ready;

    always_comb begin
        x_sum = rot_x[NSTAGE] + ROUND_HALF;
        y_sum = rot_y[NSTAGE] + ROUND_HALF;
        xr    = SW'(signed'(x_sum[XW-1:spc_pkg::FRAC_BITS]));
        yr    = SW'(signed'(y_sum[XW-1:spc_pkg::FRAC_BITS]));
        case (rot_side[NSTAGE].quad)
            spc_pkg::QUAD_0: begin
                ox = xr;
                oy = yr;
            end
            spc_pkg::QUAD_90: begin
                ox = -yr;
                oy = xr;
            end
            spc_pkg::QUAD_180: begin
                ox = -xr;
                oy = -yr;
            end
            default: begin
                ox = yr;
                oy = -xr;
            end
        endcase
        m_x_mm_next = signed'(sat_out(ox));
        m_y_mm_next = signed'(sat_out(oy));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready_int) begin
            m_valid_reg <= rot_valid[NSTAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready_int) begin
            m_x_mm_reg        <= m_x_mm_next;
            m_y_mm_reg        <= m_y_mm_next;
            m_point_index_reg <= rot_side[NSTAGE].index;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_x_mm        = m_x_mm_reg;
    assign m_y_mm        = m_y_mm_reg;
    assign m_point_index = m_point_index_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic take_invalid;
    logic take_kept;
    logic resid_ok;
    logic out_in_limit;

    assign take_invalid = s_valid && s_ready && s_sample_invalid;
    assign take_kept    = s_valid && s_ready && in_window;
    assign resid_ok     = (s2_z_reg[ZW-1] == s2_z_reg[ZW-2]) &&
                          (s2_z_reg[ZW-2] == s2_z_reg[ZW-3]);
    assign out_in_limit = (m_x_mm_reg[16] == 1'b0 || m_x_mm_reg[15:0] != 16'h0000) &&
                          (m_y_mm_reg[16] == 1'b0 || m_y_mm_reg[15:0] != 16'h0000);

    // A sample flagged invalid must never occupy the first slot.
    `SPC_ASSERT_NEXT(a_invalid_dropped, take_invalid, !s1_valid_reg, "invalid sample was kept")
    // A sample inside the range window must occupy the first slot.
    `SPC_ASSERT_NEXT(a_window_kept, take_kept, s1_valid_reg, "sample inside the window was lost")
    // Input back-pressure only when the first slot is full.
    `SPC_ASSERT_SAME(a_ready_bubble, !s_ready, s1_valid_reg, "input stalled with a bubble")
    // The folded residual angle stays within an eighth of a turn.
    `SPC_ASSERT_SAME(a_residual_range, s2_valid_reg, resid_ok, "residual angle out of range")
    // Saturation never lets the most negative code through.
    `SPC_ASSERT_SAME(a_out_saturated, m_valid_reg, out_in_limit, "coordinate beyond the limit")

endmodule
